### hw/rtl/obci_pkg.sv
// ----------------------------------------------------------------------------
// obci_pkg
// Shared types, constants and helper functions for the octree box cell index.
// ----------------------------------------------------------------------------
package obci_pkg;

    localparam int COORD_W       = 24;
    localparam int MAG_W         = 24;
    localparam int PROD_W        = 48;
    localparam int CORNERS       = 6;
    localparam int AXES          = 3;
    localparam int LEVEL_W       = 4;
    localparam int INDEX_W       = 26;
    localparam int START_W       = 22;
    localparam int CFG_INDEX_W   = 3;
    localparam int MAX_LEVEL_DEF = 8;

    localparam logic [COORD_W-1:0] ORIGIN_RST   = 24'(-64000);
    localparam logic [MAG_W-1:0]   INV_CELL_RST = 24'd2097;
    localparam logic [LEVEL_W-1:0] DIV_LEVEL_RST = 4'd4;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ORIGIN_X  = 3'd0,
        REG_ORIGIN_Y  = 3'd1,
        REG_ORIGIN_Z  = 3'd2,
        REG_INV_CELL  = 3'd3,
        REG_DIV_LEVEL = 3'd4
    } cfg_reg_t;

    // offset of one corner from the space origin
    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
    } obci_ofs_t;

    // scaled offset of one corner, Q24 fraction below bit 24
    typedef struct packed {
        logic              neg;
        logic [PROD_W-1:0] prod;
    } obci_prod_t;

    // spread 8 bits so that bit i lands on bit 3*i
    function automatic logic [23:0] obci_spread(input logic [7:0] c);
        logic [23:0] n;
        n = {16'd0, c};
        n = (n | (n << 8)) & 24'h00f00f;
        n = (n | (n << 4)) & 24'h0c30c3;
        n = (n | (n << 2)) & 24'h249249;
        return n;
    endfunction

    // first index of a level in the linear octree, (8^level - 1) / 7
    function automatic logic [START_W-1:0] obci_level_start(input logic [LEVEL_W-1:0] lvl);
        logic [START_W-1:0] s;
        case (lvl)
            4'd0:    s = 22'd0;
            4'd1:    s = 22'd1;
            4'd2:    s = 22'd9;
            4'd3:    s = 22'd73;
            4'd4:    s = 22'd585;
            4'd5:    s = 22'd4681;
            4'd6:    s = 22'd37449;
            4'd7:    s = 22'd299593;
            4'd8:    s = 22'd2396745;
            default: s = 22'd0;
        endcase
        return s;
    endfunction

endpackage

### hw/rtl/obci_offset.sv
// ----------------------------------------------------------------------------
// obci_offset
// Stage 1: subtracts the space origin from each of the six corner coordinates.
// ----------------------------------------------------------------------------
module obci_offset
    import obci_pkg::*;
(
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               in_valid,
    output logic                               ready,
    input  logic                               nxt_ready,
    input  logic [CORNERS-1:0][COORD_W-1:0]    raw,
    input  logic [AXES-1:0][COORD_W-1:0]       origin,
    output logic                               valid_reg,
    output obci_ofs_t [CORNERS-1:0]            ofs_reg
);

    logic                    valid_next;
    obci_ofs_t [CORNERS-1:0] ofs_next;

    assign ready      = !valid_reg || nxt_ready;
    assign valid_next = ready ? in_valid : valid_reg;

    always_comb begin
        logic [COORD_W:0] d;
        logic [COORD_W-1:0] org;
        for (int a = 0; a < CORNERS; a++) begin
            org = origin[(a < AXES) ? a : a - AXES];
            d   = {raw[a][COORD_W-1], raw[a]} - {org[COORD_W-1], org};
            ofs_next[a].neg = d[COORD_W];
            ofs_next[a].mag = d[MAG_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready && in_valid) begin
            ofs_reg <= ofs_next;
        end
    end

endmodule

### hw/rtl/obci_scale.sv
// ----------------------------------------------------------------------------
// obci_scale
// Stage 2: multiplies each corner offset by the reciprocal cell size.
// ----------------------------------------------------------------------------
module obci_scale
    import obci_pkg::*;
(
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        ready,
    input  logic                        nxt_ready,
    input  obci_ofs_t [CORNERS-1:0]     ofs,
    input  logic [MAG_W-1:0]            inv_cell_size,
    output logic                        valid_reg,
    output obci_prod_t [CORNERS-1:0]    prod_reg
);

    logic                     valid_next;
    obci_prod_t [CORNERS-1:0] prod_next;

    assign ready      = !valid_reg || nxt_ready;
    assign valid_next = ready ? in_valid : valid_reg;

    always_comb begin
        for (int a = 0; a < CORNERS; a++) begin
            prod_next[a].neg  = ofs[a].neg;
            prod_next[a].prod = PROD_W'(ofs[a].mag) * PROD_W'(inv_cell_size);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready && in_valid) begin
            prod_reg <= prod_next;
        end
    end

endmodule

### hw/rtl/obci_cell.sv
// ----------------------------------------------------------------------------
// obci_cell
// Stage 3: bounds check, floor and clamp to cell coordinates, Morton codes.
// ----------------------------------------------------------------------------
module obci_cell
    import obci_pkg::*;
#(
    parameter int MAX_LEVEL = MAX_LEVEL_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          ready,
    input  logic                          nxt_ready,
    input  obci_prod_t [CORNERS-1:0]      prod,
    input  logic [LEVEL_W-1:0]            eff_level,
    output logic                          valid_reg,
    output logic                          outside_reg,
    output logic [3*MAX_LEVEL-1:0]        code_lo_reg,
    output logic [3*MAX_LEVEL-1:0]        code_hi_reg
);

    localparam int CELL_W = MAX_LEVEL;
    localparam int CODE_W = 3 * MAX_LEVEL;

    logic                              valid_next;
    logic                              outside_next;
    logic [CODE_W-1:0]                 code_lo_next;
    logic [CODE_W-1:0]                 code_hi_next;
    logic [CORNERS-1:0][CELL_W-1:0]    cell_pos;
    logic [CORNERS-1:0]                corner_out;

    assign ready      = !valid_reg || nxt_ready;
    assign valid_next = ready ? in_valid : valid_reg;

    always_comb begin
        logic [MAG_W-1:0] hi;
        logic [MAG_W-1:0] lim;
        logic             over;
        lim = MAG_W'(1) << eff_level;
        for (int a = 0; a < CORNERS; a++) begin
            hi   = prod[a].prod[PROD_W-1:MAG_W];
            // strictly above the upper face is outside
            over = (hi > lim) || ((hi == lim) && (|prod[a].prod[MAG_W-1:0]));
            corner_out[a] = prod[a].neg || over;
            // a corner on the upper face falls into the last cell
            cell_pos[a] = (hi >= lim) ? CELL_W'(lim - MAG_W'(1)) : hi[CELL_W-1:0];
        end
    end

    assign outside_next = |corner_out;
    assign code_lo_next = CODE_W'(obci_spread(8'(cell_pos[0]))
                                  | (obci_spread(8'(cell_pos[1])) << 1)
                                  | (obci_spread(8'(cell_pos[2])) << 2));
    assign code_hi_next = CODE_W'(obci_spread(8'(cell_pos[3]))
                                  | (obci_spread(8'(cell_pos[4])) << 1)
                                  | (obci_spread(8'(cell_pos[5])) << 2));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready && in_valid) begin
            outside_reg <= outside_next;
            code_lo_reg <= code_lo_next;
            code_hi_reg <= code_hi_next;
        end
    end

endmodule

### hw/rtl/obci_level.sv
// ----------------------------------------------------------------------------
// obci_level
// Stage 4: finds the deepest level that holds both codes and forms the
// linear octree index; its registers are the output register.
// ----------------------------------------------------------------------------
module obci_level
    import obci_pkg::*;
#(
    parameter int MAX_LEVEL = MAX_LEVEL_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        ready,
    input  logic                        nxt_ready,
    input  logic                        outside,
    input  logic [3*MAX_LEVEL-1:0]      code_lo,
    input  logic [3*MAX_LEVEL-1:0]      code_hi,
    input  logic [LEVEL_W-1:0]          eff_level,
    output logic                        valid_reg,
    output logic                        outside_reg,
    output logic [LEVEL_W-1:0]          level_reg,
    output logic [INDEX_W-1:0]          index_reg
);

    localparam int CODE_W = 3 * MAX_LEVEL;

    logic                  valid_next;
    logic [MAX_LEVEL-1:0]  grp_nz;
    logic [LEVEL_W-1:0]    groups;
    logic [4:0]            shamt;
    logic [CODE_W-1:0]     shifted;
    logic [LEVEL_W-1:0]    level_next;
    logic [INDEX_W-1:0]    index_next;
    logic [CODE_W-1:0]     code_x;

    assign ready      = !valid_reg || nxt_ready;
    assign valid_next = ready ? in_valid : valid_reg;
    assign code_x     = code_lo ^ code_hi;

    // number of 3-bit groups up to the highest one where the corners differ
    always_comb begin
        groups = '0;
        for (int k = 0; k < MAX_LEVEL; k++) begin
            grp_nz[k] = |code_x[3*k +: 3];
            if (grp_nz[k]) begin
                groups = LEVEL_W'(k + 1);
            end
        end
    end

    assign shamt   = 5'({groups, 1'b0}) + 5'(groups);
    assign shifted = code_hi >> shamt;

    always_comb begin
        if (outside) begin
            level_next = '0;
            index_next = '1;
        end else begin
            level_next = eff_level - groups;
            index_next = INDEX_W'(shifted) + INDEX_W'(obci_level_start(eff_level - groups));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready && in_valid) begin
            outside_reg <= outside;
            level_reg   <= level_next;
            index_reg   <= index_next;
        end
    end

endmodule

### hw/rtl/octree_box_cell_index.sv
// ----------------------------------------------------------------------------
// octree_box_cell_index
// Linear octree cell index of an axis-aligned box given by two Q15.8 corners.
//
//   channel  dir  beat fields (low bit up)
//   s_       in   tdata: min_x, min_y, min_z, max_x, max_y, max_z (24 each)
//   m_       out  tdata: cell_index(26), cell_level(4), 2 zero bits
//                 tuser: outside(1)
//   cfg_     in   cfg_index(3), cfg_data(24)
//
// Four register stages: origin offset, scale multiply, clamp and Morton
// interleave, level search and index add. One box per cycle enters while
// m_tready is high, since every stage is registered and takes a new beat
// unless stalled; the six 24x24 multipliers of stage 2 set the stage depth.
// Each stage stalls only when it holds a beat and the next one is full, so
// bubbles close up while m_tready is low. Reset clears the stage valid bits
// and loads the register defaults; cfg_ready is always high.
// ----------------------------------------------------------------------------
module octree_box_cell_index
    import obci_pkg::*;
#(
    parameter int MAX_LEVEL = MAX_LEVEL_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [143:0]              s_tdata,   // min_x, min_y, min_z, max_x, max_y, max_z
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [31:0]               m_tdata,   // cell_index, cell_level, zero pad
    output logic [0:0]                m_tuser,   // outside
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_W-1:0]    cfg_index,
    input  logic [COORD_W-1:0]        cfg_data
);

    localparam int CODE_W = 3 * MAX_LEVEL;

    logic [AXES-1:0][COORD_W-1:0]  origin_reg;
    logic [MAG_W-1:0]              inv_cell_reg;
    logic [LEVEL_W-1:0]            div_level_reg;
    logic [LEVEL_W-1:0]            eff_level;

    logic [CORNERS-1:0][COORD_W-1:0] raw;

    logic                      s1_ready, s1_valid;
    obci_ofs_t [CORNERS-1:0]   s1_ofs;
    logic                      s2_ready, s2_valid;
    obci_prod_t [CORNERS-1:0]  s2_prod;
    logic                      s3_ready, s3_valid, s3_outside;
    logic [CODE_W-1:0]         s3_code_lo, s3_code_hi;
    logic                      s4_ready, s4_valid, s4_outside;
    logic [LEVEL_W-1:0]        s4_level;
    logic [INDEX_W-1:0]        s4_index;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_reg    <= {AXES{ORIGIN_RST}};
            inv_cell_reg  <= INV_CELL_RST;
            div_level_reg <= DIV_LEVEL_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_reg_t'(cfg_index))
                REG_ORIGIN_X:  origin_reg[0] <= cfg_data;
                REG_ORIGIN_Y:  origin_reg[1] <= cfg_data;
                REG_ORIGIN_Z:  origin_reg[2] <= cfg_data;
                REG_INV_CELL:  inv_cell_reg  <= cfg_data;
                REG_DIV_LEVEL: div_level_reg <= cfg_data[LEVEL_W-1:0];
                default: ;
            endcase
        end
    end

    assign eff_level = (div_level_reg > LEVEL_W'(MAX_LEVEL)) ? LEVEL_W'(MAX_LEVEL)
                                                              : div_level_reg;

    always_comb begin
        for (int a = 0; a < CORNERS; a++) begin
            raw[a] = s_tdata[a*COORD_W +: COORD_W];
        end
    end

    assign s_tready = s1_ready;

    obci_offset u_offset (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .ready     (s1_ready),
        .nxt_ready (s2_ready),
        .raw       (raw),
        .origin    (origin_reg),
        .valid_reg (s1_valid),
        .ofs_reg   (s1_ofs)
    );

    obci_scale u_scale (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s1_valid),
        .ready         (s2_ready),
        .nxt_ready     (s3_ready),
        .ofs           (s1_ofs),
        .inv_cell_size (inv_cell_reg),
        .valid_reg     (s2_valid),
        .prod_reg      (s2_prod)
    );

    obci_cell #(
        .MAX_LEVEL (MAX_LEVEL)
    ) u_cell (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s2_valid),
        .ready       (s3_ready),
        .nxt_ready   (s4_ready),
        .prod        (s2_prod),
        .eff_level   (eff_level),
        .valid_reg   (s3_valid),
        .outside_reg (s3_outside),
        .code_lo_reg (s3_code_lo),
        .code_hi_reg (s3_code_hi)
    );

    obci_level #(
        .MAX_LEVEL (MAX_LEVEL)
    ) u_level (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s3_valid),
        .ready       (s4_ready),
        .nxt_ready   (m_tready),
        .outside     (s3_outside),
        .code_lo     (s3_code_lo),
        .code_hi     (s3_code_hi),
        .eff_level   (eff_level),
        .valid_reg   (s4_valid),
        .outside_reg (s4_outside),
        .level_reg   (s4_level),
        .index_reg   (s4_index)
    );

    assign m_tvalid = s4_valid;
    assign m_tdata  = {2'b00, s4_level, s4_index};
    assign m_tuser  = s4_outside;

    // input only stalls when every stage holds a beat
    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (s1_valid && s2_valid && s3_valid && s4_valid))
        else $error("input stalled with a bubble in the pipeline");

    a_outside_code: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (s4_level == '0 && s4_index == '1))
        else $error("outside beat without index -1 at level 0");

    a_level_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (s4_level <= eff_level))
        else $error("cell level deeper than levels in use");

    a_index_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (s4_index >= INDEX_W'(obci_level_start(s4_level))))
        else $error("cell index below the start of its level");

endmodule
